@@ rtl/core/dcr_pkg.sv @@
// Package for the delayed clock replacement block: sequencer states and shared widths.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
package dcr_pkg;
    localparam int CFG_W   = 11;
    localparam int PROMO_W = 14;
    localparam logic [PROMO_W-1:0] PROMO_MAX = {PROMO_W{1'b1}};
    localparam logic [1:0] REG_ENTRIES     = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE = 2'd1;
    localparam logic [1:0] REG_FREQ_LIMIT  = 2'd2;
    localparam logic MODE_ACCESS = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HITCHK,
        ST_EVCHK,
        ST_EVRD,
        ST_PROMO_WIN,
        ST_PROMO_WR,
        ST_INS_WIN,
        ST_INS_WR,
        ST_DONE
    } dcr_state_t;
endpackage

@@ rtl/core/dcr_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/core/delayed_clock_replacement_top.sv @@
// Top level of the delayed clock replacement cache: control sequencer, one ring RAM.
// Depends on dcr_pkg and dcr_ram.
//
// Usage: requests (mode, object_id) transfer on the input channel (valid/stall);
// one result (hit, evict_valid, evicted_id, promotions) transfers per request on
// the output channel. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle.
// All entry state (tag, count, deferred count) lives in one single-port RAM with
// registered read data; each step makes at most one RAM access. A request searches
// the occupied slots from the back; a hit ends the search. An access miss then
// evicts or promotes entries at the back while the ring is full, updates the entry
// leaving the window if there is one, and writes the new entry at the front.
// One item is worked at a time; input stall is high while busy or while a result
// waits. The result sits in an output register until taken, then the next item
// is accepted.
// Reset clears back index, occupancy, sequencer and output valid; RAM contents
// are not cleared (only occupied slots are read). The entry limit resets to 1024,
// the window to 103 and the count limit to 1.
// A stalled receiver holds the result and the block.
`timescale 1ns / 1ps
module delayed_clock_replacement_top #(
    parameter int CAPACITY   = 1024,
    parameter int ID_BITS    = 32,
    parameter int COUNT_BITS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [dcr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [ID_BITS-1:0]          object_id,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hit,
    output logic                        evict_valid,
    output logic [31:0]                 evicted_id,
    output logic [dcr_pkg::PROMO_W-1:0] promotions
);
    import dcr_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int OW = AW + 1;
    localparam int DW = ID_BITS + 2 * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [CFG_W-1:0] csize_reg, win_reg;
    logic [3:0]       flim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csize_reg <= CFG_W'(1024);
            win_reg   <= CFG_W'(103);
            flim_reg  <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENTRIES:     csize_reg <= cfg_data;
                REG_WINDOW_SIZE: win_reg   <= cfg_data;
                REG_FREQ_LIMIT:  flim_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective limits; size and window widened to occupancy width + 1
    logic [OW:0] size_eff, win_eff;
    logic [COUNT_BITS-1:0] lim_eff;
    always_comb
    begin
        if (csize_reg == '0)
            size_eff = (OW+1)'(1);
        else if ({{(OW+1){1'b0}}, csize_reg} > (OW+1+CFG_W)'(CAPACITY))
            size_eff = (OW+1)'(CAPACITY);
        else
            size_eff = (OW+1)'(csize_reg);
        if (win_reg == '0)
            win_eff = (OW+1)'(1);
        else if ({{(OW+1){1'b0}}, win_reg} > (OW+1+CFG_W)'(CAPACITY + 1))
            win_eff = (OW+1)'(CAPACITY + 1);
        else
            win_eff = (OW+1)'(win_reg);
        if ({4'd0, flim_reg} > 8'(CMAX))
            lim_eff = CMAX;
        else
            lim_eff = COUNT_BITS'(flim_reg);
    end

    // state registers
    dcr_state_t state_reg, state_next;
    logic [AW-1:0] back_reg, back_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic [OW-1:0] idx_reg, idx_next;
    logic          mode_reg, mode_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [DW-1:0] ent_reg, ent_next;      // held entry (victim / promoted)
    logic [AW-1:0] fslot_reg, fslot_next;
    logic          hit_reg, hit_next;
    logic          evv_reg, evv_next;
    logic [31:0]   evid_reg, evid_next;
    logic [PROMO_W-1:0] promo_reg, promo_next;
    logic          ov_reg, ov_next;

    // RAM
    logic          we;
    logic [AW-1:0] addr;
    logic [DW-1:0] wdata, rdata;
    dcr_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [ID_BITS-1:0]    r_tag;
    logic [COUNT_BITS-1:0] r_cnt, r_def;
    assign r_tag = rdata[DW-1 -: ID_BITS];
    assign r_cnt = rdata[2*COUNT_BITS-1 -: COUNT_BITS];
    assign r_def = rdata[COUNT_BITS-1:0];

    // ring slot of offset off from back
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] b, input logic [OW:0] off);
        logic [OW+1:0] s;
        s = (OW+2)'(b) + (OW+2)'(off);
        if (s >= (OW+2)'(CAPACITY))
            s = s - (OW+2)'(CAPACITY);
        return s[AW-1:0];
    endfunction

    logic [OW:0] occ_w;
    assign occ_w = (OW+1)'(occ_reg);

    always_comb
    begin
        state_next = state_reg;
        back_next  = back_reg;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        mode_next  = mode_reg;
        id_next    = id_reg;
        ent_next   = ent_reg;
        fslot_next = fslot_reg;
        hit_next   = hit_reg;
        evv_next   = evv_reg;
        evid_next  = evid_reg;
        promo_next = promo_reg;
        ov_next    = ov_reg;
        we    = 1'b0;
        addr  = slot_of(back_reg, (OW+1)'(idx_reg));
        wdata = ent_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    mode_next  = mode;
                    id_next    = object_id;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    evv_next   = 1'b0;
                    evid_next  = '0;
                    promo_next = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // issue read of offset idx
                if (idx_reg >= occ_reg)
                    state_next = (mode_reg == MODE_ACCESS) ? ST_EVCHK : ST_DONE;
                else
                begin
                    fslot_next = addr;
                    state_next = ST_HITCHK;
                end
            end
            ST_HITCHK:
            begin
                addr = fslot_reg;
                if (r_tag == id_reg)
                begin
                    hit_next = 1'b1;
                    if (mode_reg == MODE_ACCESS && r_cnt < lim_eff)
                    begin
                        we    = 1'b1;
                        wdata = {r_tag, r_cnt + COUNT_BITS'(1), r_def};
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + OW'(1);
                    state_next = ST_SEARCH;
                end
            end
            ST_EVCHK:
            begin
                // read oldest entry if still full; restart the window read phase
                addr     = back_reg;
                idx_next = '0;
                if (occ_w >= size_eff)
                    state_next = ST_EVRD;
                else
                    state_next = (occ_w >= win_eff) ? ST_INS_WIN : ST_INS_WR;
            end
            ST_EVRD:
            begin
                addr = back_reg;
                if (r_cnt == '0)
                begin
                    if (!evv_reg)
                    begin
                        evv_next  = 1'b1;
                        evid_next = 32'(r_tag);
                    end
                    back_next  = slot_of(back_reg, (OW+1)'(1));
                    occ_next   = occ_reg - OW'(1);
                    state_next = ST_EVCHK;
                end
                else
                begin
                    if (win_eff >= occ_w)
                    begin
                        ent_next   = {r_tag, r_cnt - COUNT_BITS'(1), r_cnt - COUNT_BITS'(1)};
                        state_next = ST_PROMO_WR;
                    end
                    else
                    begin
                        ent_next   = {r_tag, r_cnt, r_cnt - COUNT_BITS'(1)};
                        state_next = ST_PROMO_WIN;
                        idx_next   = '0;
                    end
                end
            end
            ST_PROMO_WIN:
            begin
                // read the entry leaving the window (offset occ - win)
                addr = slot_of(back_reg, occ_w - win_eff);
                if (idx_reg == '0)
                    idx_next = OW'(1);
                else
                begin
                    we    = 1'b1;
                    wdata = {r_tag, r_def, r_def};
                    idx_next = '0;
                    state_next = ST_PROMO_WR;
                end
            end
            ST_PROMO_WR:
            begin
                addr  = slot_of(back_reg, occ_w);
                we    = 1'b1;
                wdata = ent_reg;
                back_next = slot_of(back_reg, (OW+1)'(1));
                if (promo_reg != PROMO_MAX)
                    promo_next = promo_reg + PROMO_W'(1);
                state_next = ST_EVCHK;
            end
            ST_INS_WIN:
            begin
                addr = slot_of(back_reg, occ_w - win_eff);
                if (idx_reg == '0)
                    idx_next = OW'(1);
                else
                begin
                    we    = 1'b1;
                    wdata = {r_tag, r_def, r_def};
                    idx_next = '0;
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR:
            begin
                addr  = slot_of(back_reg, occ_w);
                we    = 1'b1;
                wdata = {id_reg, {(2*COUNT_BITS){1'b0}}};
                occ_next   = occ_reg + OW'(1);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            back_reg  <= '0;
            occ_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            back_reg  <= back_next;
            occ_reg   <= occ_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        mode_reg  <= mode_next;
        id_reg    <= id_next;
        ent_reg   <= ent_next;
        fslot_reg <= fslot_next;
        hit_reg   <= hit_next;
        evv_reg   <= evv_next;
        evid_reg  <= evid_next;
        promo_reg <= promo_next;
    end

    assign in_stall    = (state_reg != ST_IDLE) || ov_reg;
    assign out_valid   = ov_reg;
    assign hit         = hit_reg;
    assign evict_valid = evv_reg;
    assign evicted_id  = evid_reg;
    assign promotions  = promo_reg;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(CAPACITY)) else $error("occupancy above capacity");
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evict_valid && promotions == '0)
        else $error("hit with eviction");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall) else $error("accept while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && state_next == ST_IDLE |=> out_valid)
        else $error("result lost");
`endif
endmodule
